// ===== rtl/deq_pkg.sv =====
// Shared types, constants and index helpers for the double-ended queue.
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 8;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;
  localparam logic [2:0] MODE_NOP        = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [DATA_WIDTH-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data_out;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] rear_value;
    logic                  is_empty;
    logic [CW-1:0]         occupancy;
  } out_item_t;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + AW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = i - AW'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue: ring buffer in RAM with cached front and rear elements.
//
// A request is taken when start is high and busy is low. busy is high while the
// block sits in its fetch state after acceptance; the result is registered from
// that state and shows on out_item with out_valid high for exactly one cycle.
// No new request is taken while busy is high, as the fetch state waits on the slot
// RAM, which refetches the new front or rear element after a pop. The result can
// not be held off, so it must be taken in the cycle that out_valid is high; a new
// request may be accepted in that same cycle.
module double_ended_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output deq_pkg::out_item_t out_item
);

  localparam int AW = deq_pkg::AW;
  localparam int CW = deq_pkg::CW;
  localparam int DW = deq_pkg::DATA_WIDTH;

  deq_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [DW-1:0]      front_r, front_nxt;
  logic [DW-1:0]      rear_r, rear_nxt;
  logic [DW-1:0]      popped_r, popped_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               ldf_r, ldf_nxt;
  logic               ldr_r, ldr_nxt;
  logic               out_valid_r, out_valid_nxt;
  deq_pkg::out_item_t out_item_r, out_item_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [DW-1:0]      ram_rdata;
  logic [AW-1:0]      tail_prev;
  logic [DW-1:0]      front_val;
  logic [DW-1:0]      rear_val;
  logic               empty_after;

  deq_ram #(
    .WIDTH (DW),
    .DEPTH (deq_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.data_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full      = (count_r == CW'(deq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign tail_prev = deq_pkg::idx_prev(tail_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = deq_pkg::ST_FETCH;
        end
      end
      deq_pkg::ST_FETCH: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy          = 1'b0;
    accept        = 1'b0;
    out_valid_nxt = 1'b0;
    case (state_r)
      deq_pkg::ST_IDLE: begin
        accept = start;
      end
      deq_pkg::ST_FETCH: begin
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // request execution and result assembly
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    ldf_nxt    = ldf_r;
    ldr_nxt    = ldr_r;
    ram_we     = 1'b0;
    ram_waddr  = head_r;
    ram_raddr  = head_r;

    front_val    = ldf_r ? ram_rdata : front_r;
    rear_val     = ldr_r ? ram_rdata : rear_r;
    empty_after  = (count_r == '0);
    out_item_nxt = out_item_r;

    if (accept) begin
      popped_nxt = '0;
      status_nxt = deq_pkg::STATUS_OK;
      ldf_nxt    = 1'b0;
      ldr_nxt    = 1'b0;
      case (in_item.mode)
        deq_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::STATUS_FULL;
          end else begin
            head_nxt  = deq_pkg::idx_prev(head_r);
            ram_we    = 1'b1;
            ram_waddr = deq_pkg::idx_prev(head_r);
            front_nxt = in_item.data_in;
            if (empty) begin
              rear_nxt = in_item.data_in;
            end
            count_nxt = count_r + CW'(1);
          end
        end
        deq_pkg::MODE_PUSH_REAR: begin
          if (full) begin
            status_nxt = deq_pkg::STATUS_FULL;
          end else begin
            tail_nxt  = deq_pkg::idx_next(tail_r);
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            rear_nxt  = in_item.data_in;
            if (empty) begin
              front_nxt = in_item.data_in;
            end
            count_nxt = count_r + CW'(1);
          end
        end
        deq_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::STATUS_EMPTY;
          end else begin
            popped_nxt = front_r;
            head_nxt   = deq_pkg::idx_next(head_r);
            count_nxt  = count_r - CW'(1);
            if (count_r == CW'(2)) begin
              front_nxt = rear_r;
            end else if (count_r > CW'(2)) begin
              ram_raddr = deq_pkg::idx_next(head_r);
              ldf_nxt   = 1'b1;
            end
          end
        end
        deq_pkg::MODE_POP_REAR: begin
          if (empty) begin
            status_nxt = deq_pkg::STATUS_EMPTY;
          end else begin
            popped_nxt = rear_r;
            tail_nxt   = tail_prev;
            count_nxt  = count_r - CW'(1);
            if (count_r == CW'(2)) begin
              rear_nxt = front_r;
            end else if (count_r > CW'(2)) begin
              ram_raddr = deq_pkg::idx_prev(tail_prev);
              ldr_nxt   = 1'b1;
            end
          end
        end
        default: begin
          status_nxt = deq_pkg::STATUS_OK;
        end
      endcase
    end

    if (out_valid_nxt) begin
      front_nxt                = front_val;
      rear_nxt                 = rear_val;
      out_item_nxt.data_out    = popped_r;
      out_item_nxt.status      = status_r;
      out_item_nxt.front_value = empty_after ? '0 : front_val;
      out_item_nxt.rear_value  = empty_after ? '0 : rear_val;
      out_item_nxt.is_empty    = empty_after;
      out_item_nxt.occupancy   = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ldf_r       <= 1'b0;
      ldr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ldf_r       <= ldf_nxt;
      ldr_r       <= ldr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    rear_r     <= rear_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== test/deq_checker.sv =====
// Checker for the double-ended queue: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module deq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  deq_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  deq_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 awaited_count
);

  logic [deq_pkg::DATA_WIDTH-1:0] ring_slots [deq_pkg::DEPTH];
  logic [deq_pkg::AW-1:0]         front_idx;
  logic [deq_pkg::AW-1:0]         back_idx;
  logic [deq_pkg::CW-1:0]         stored;
  deq_pkg::out_item_t             awaited_results [$];
  int                             fails = 0;

  function automatic logic [deq_pkg::AW-1:0] ring_fwd(input logic [deq_pkg::AW-1:0] i);
    return (i == deq_pkg::AW'(deq_pkg::DEPTH - 1)) ? '0 : i + deq_pkg::AW'(1);
  endfunction

  function automatic logic [deq_pkg::AW-1:0] ring_back(input logic [deq_pkg::AW-1:0] i);
    return (i == '0) ? deq_pkg::AW'(deq_pkg::DEPTH - 1) : i - deq_pkg::AW'(1);
  endfunction

  function automatic deq_pkg::out_item_t apply_request(input deq_pkg::in_item_t req);
    deq_pkg::out_item_t r;
    logic               full;
    logic               empty;
    r     = '0;
    full  = (stored == deq_pkg::CW'(deq_pkg::DEPTH));
    empty = (stored == '0);
    case (req.mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          r.status = deq_pkg::STATUS_FULL;
        end else begin
          front_idx             = ring_back(front_idx);
          ring_slots[front_idx] = req.data_in;
          stored                = stored + deq_pkg::CW'(1);
        end
      end
      deq_pkg::MODE_PUSH_REAR: begin
        if (full) begin
          r.status = deq_pkg::STATUS_FULL;
        end else begin
          ring_slots[back_idx] = req.data_in;
          back_idx             = ring_fwd(back_idx);
          stored               = stored + deq_pkg::CW'(1);
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          r.data_out = ring_slots[front_idx];
          front_idx  = ring_fwd(front_idx);
          stored     = stored - deq_pkg::CW'(1);
        end
      end
      deq_pkg::MODE_POP_REAR: begin
        if (empty) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          back_idx   = ring_back(back_idx);
          r.data_out = ring_slots[back_idx];
          stored     = stored - deq_pkg::CW'(1);
        end
      end
      default: begin
        r.status = deq_pkg::STATUS_OK;
      end
    endcase
    if (stored == '0) begin
      r.is_empty = 1'b1;
    end else begin
      r.front_value = ring_slots[front_idx];
      r.rear_value  = ring_slots[ring_back(back_idx)];
    end
    r.occupancy = stored;
    return r;
  endfunction

  always @(posedge clk) begin
    deq_pkg::out_item_t exp_item;
    if (!rst_n) begin
      front_idx = '0;
      back_idx  = '0;
      stored    = '0;
      for (int k = 0; k < deq_pkg::DEPTH; k++) begin
        ring_slots[k] = '0;
      end
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with no item awaiting it");
          fails++;
        end else begin
          exp_item = awaited_results.pop_front();
          if (out_item.data_out !== exp_item.data_out) begin
            $error("data_out: expected %0d, actual %0d", exp_item.data_out, out_item.data_out);
            fails++;
          end
          if (out_item.status !== exp_item.status) begin
            $error("status: expected %0d, actual %0d", exp_item.status, out_item.status);
            fails++;
          end
          if (out_item.front_value !== exp_item.front_value) begin
            $error("front_value: expected %0d, actual %0d",
                   exp_item.front_value, out_item.front_value);
            fails++;
          end
          if (out_item.rear_value !== exp_item.rear_value) begin
            $error("rear_value: expected %0d, actual %0d",
                   exp_item.rear_value, out_item.rear_value);
            fails++;
          end
          if (out_item.is_empty !== exp_item.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", exp_item.is_empty, out_item.is_empty);
            fails++;
          end
          if (out_item.occupancy !== exp_item.occupancy) begin
            $error("occupancy: expected %0d, actual %0d",
                   exp_item.occupancy, out_item.occupancy);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_request(in_item));
      end
    end
    fail_count    <= fails;
    awaited_count <= awaited_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the double-ended queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int         IDLE_LIMIT    = 2000;
  localparam int         RANDOM_ITEMS  = 1350;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  deq_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_valid;
  deq_pkg::out_item_t out_item;
  int                 fail_count;
  int                 awaited_count;
  int                 idle_cycles = 0;
  int                 gap_style   = 1;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  deq_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_style == 0 || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [2:0] pick_mode(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return 3'($urandom_range(deq_pkg::MODE_NOP, MODE_SPARE_HI));
    end else if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_REAR : deq_pkg::MODE_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? deq_pkg::MODE_POP_REAR : deq_pkg::MODE_POP_FRONT;
  endfunction

  function automatic logic [deq_pkg::DATA_WIDTH-1:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end else if (r < 16) begin
      return '1;
    end
    return deq_pkg::DATA_WIDTH'($urandom);
  endfunction

  task automatic send_request(input logic [2:0] mode,
                              input logic [deq_pkg::DATA_WIDTH-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{mode: mode, data_in: data};
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  initial begin
    int push_pct;
    push_pct = 50;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_request(deq_pkg::MODE_POP_FRONT, '1);
    send_request(deq_pkg::MODE_POP_REAR, '1);
    send_request(deq_pkg::MODE_NOP, '1);
    send_request(MODE_SPARE_HI, 8'h5A);
    send_request(deq_pkg::MODE_PUSH_FRONT, '1);
    send_request(deq_pkg::MODE_POP_REAR, '0);
    send_request(deq_pkg::MODE_PUSH_REAR, '0);
    send_request(deq_pkg::MODE_POP_FRONT, '1);
    for (int k = 0; k < deq_pkg::DEPTH; k++) begin
      send_request(k[0] ? deq_pkg::MODE_PUSH_REAR : deq_pkg::MODE_PUSH_FRONT,
                   deq_pkg::DATA_WIDTH'(k * 17 + 1));
    end
    send_request(deq_pkg::MODE_PUSH_FRONT, 8'hAA);
    send_request(deq_pkg::MODE_PUSH_REAR, 8'h55);
    send_request(MODE_SPARE_LO, '1);
    send_request(deq_pkg::MODE_POP_FRONT, '0);
    send_request(deq_pkg::MODE_POP_REAR, '0);
    wait_all_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
        gap_style = $urandom_range(0, 3);
      end
      if (i % 150 == 149) begin
        wait_all_results();
      end
      send_request(pick_mode(push_pct), pick_data());
    end
    wait_all_results();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && awaited_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
